@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value store: field widths,
// action codes, controller states and the shift command of the cell row.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Port field widths
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int OCC_W    = 5;
    localparam int COUNT_W  = 32;
    localparam int CAP_W    = 5;

    // Defaults of the top-level parameters
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request action codes; the codes above clear do nothing
    typedef enum logic [ACTION_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_PUT    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_EXISTS = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    // Controller sequence
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ENCODE,
        ST_UPDATE
    } t_state;

    // Movement of the cell row; position 0 is the most recent entry
    typedef enum logic [1:0] {
        SH_HOLD,    // keep every cell
        SH_TOUCH,   // cells up to the hit take their left neighbor
        SH_INSERT,  // every cell takes its left neighbor
        SH_REMOVE   // cells from the hit on take their right neighbor
    } t_shift;

endpackage

@@ rtl/lkv_if.sv @@
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels of the LRU key-value store: request and response.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value_in;

    modport source (output valid, action, key, value_in, input ready);
    modport sink   (input valid, action, key, value_in, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [VALUE_W-1:0] value_out;
    logic [OCC_W-1:0]   occupancy;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;

    modport source (output valid, found, value_out, occupancy, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, found, value_out, occupancy, hit_total, miss_total,
                    output ready);
endinterface

@@ rtl/lru_key_value_store_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_store_top
// Fully associative key-value store with least-recently-used replacement,
// built as a row of cells ordered by recency.
//
//   channel   dir   handshake      payload
//   i_req     in    valid/ready    action, key, value_in
//   o_rsp     out   valid/ready    found, value_out, occupancy, hit_total,
//                                  miss_total
//   config    in    i_cfg_we       i_cfg_data (capacity limit)
//
// A transaction steps through accept, key compare in every cell, hit
// encode, then the row shift; the response is valid the cycle after that.
// The next request is taken once the sequencer is back in idle.
// Reset empties the store at once through the occupancy count.
// A stalled response holds in its register; the update waits while it is full.
// ----------------------------------------------------------------------------
module lru_key_value_store_top #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_data
);
    import lkv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES+1);

    t_shift                w_op;
    logic [CW-1:0]         w_used;
    logic [KEY_BITS-1:0]   w_req_key;
    logic [VALUE_BITS-1:0] w_load_val;
    logic                  w_found;
    logic [IW-1:0]         w_pos;
    logic [VALUE_BITS-1:0] w_hit_val;
    logic [KEY_BITS-1:0]   w_key [ENTRIES];
    logic [VALUE_BITS-1:0] w_val [ENTRIES];
    logic [ENTRIES-1:0]    w_match;

    lkv_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_found    (w_found),
        .i_hit_val  (w_hit_val),
        .o_op       (w_op),
        .o_used     (w_used),
        .o_key      (w_req_key),
        .o_load_val (w_load_val)
    );

    // Cell row: position 0 takes new entries, the far end drops them
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_left_key;
        logic [VALUE_BITS-1:0] w_left_val;
        logic [KEY_BITS-1:0]   w_right_key;
        logic [VALUE_BITS-1:0] w_right_val;

        if (g == 0) begin : g_head
            assign w_left_key = w_req_key;
            assign w_left_val = w_load_val;
        end else begin : g_body
            assign w_left_key = w_key[g-1];
            assign w_left_val = w_val[g-1];
        end

        if (g == ENTRIES-1) begin : g_tail
            assign w_right_key = '0;
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
            assign w_right_val = w_val[g+1];
        end

        lkv_cell #(
            .ENTRIES    (ENTRIES),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_pos       (w_pos),
            .i_used      (w_used),
            .i_req_key   (w_req_key),
            .i_left_key  (w_left_key),
            .i_left_val  (w_left_val),
            .i_right_key (w_right_key),
            .i_right_val (w_right_val),
            .o_key       (w_key[g]),
            .o_val       (w_val[g]),
            .o_match     (w_match[g])
        );
    end

    lkv_encoder #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_encoder (
        .i_clk     (i_clk),
        .i_match   (w_match),
        .i_val     (w_val),
        .o_found   (w_found),
        .o_pos     (w_pos),
        .o_hit_val (w_hit_val)
    );

endmodule

@@ rtl/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell
// One entry of the recency-ordered row: holds a key and a value, compares
// its key against the request and moves its entry to a neighbor on command.
// ----------------------------------------------------------------------------
module lkv_cell #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64,
    parameter int IDX        = 0
) (
    input  logic                           i_clk,
    input  lkv_pkg::t_shift                i_op,
    input  logic [$clog2(ENTRIES)-1:0]     i_pos,
    input  logic [$clog2(ENTRIES+1)-1:0]   i_used,
    input  logic [KEY_BITS-1:0]            i_req_key,
    input  logic [KEY_BITS-1:0]            i_left_key,
    input  logic [VALUE_BITS-1:0]          i_left_val,
    input  logic [KEY_BITS-1:0]            i_right_key,
    input  logic [VALUE_BITS-1:0]          i_right_val,
    output logic [KEY_BITS-1:0]            o_key,
    output logic [VALUE_BITS-1:0]          o_val,
    output logic                           o_match
);
    import lkv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES+1);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_match;
    logic [KEY_BITS-1:0]   n_key;
    logic [VALUE_BITS-1:0] n_val;
    logic                  w_valid;
    logic                  w_upto_pos;
    logic                  w_from_pos;

    // Valid entries form a prefix of the row
    assign w_valid    = CW'(IDX) < i_used;
    assign w_upto_pos = IW'(IDX) <= i_pos;
    assign w_from_pos = IW'(IDX) >= i_pos;

    // Pick the source of the next entry
    always_comb begin
        n_key = r_key;
        n_val = r_val;
        unique case (i_op)
            SH_HOLD: begin
            end
            SH_TOUCH: begin
                if (w_upto_pos) begin
                    n_key = i_left_key;
                    n_val = i_left_val;
                end
            end
            SH_INSERT: begin
                n_key = i_left_key;
                n_val = i_left_val;
            end
            SH_REMOVE: begin
                if (w_from_pos) begin
                    n_key = i_right_key;
                    n_val = i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the entry and register the key compare
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_val   <= n_val;
        r_match <= w_valid && (r_key == i_req_key);
    end

    assign o_key   = r_key;
    assign o_val   = r_val;
    assign o_match = r_match;

endmodule

@@ rtl/lkv_encoder.sv @@
// ----------------------------------------------------------------------------
// lkv_encoder
// Turns the match flags of the row into a hit flag, the hit position and
// the stored value of the hit, all registered.
// ----------------------------------------------------------------------------
module lkv_encoder #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64
) (
    input  logic                        i_clk,
    input  logic [ENTRIES-1:0]          i_match,
    input  logic [VALUE_BITS-1:0]       i_val [ENTRIES],
    output logic                        o_found,
    output logic [$clog2(ENTRIES)-1:0]  o_pos,
    output logic [VALUE_BITS-1:0]       o_hit_val
);
    localparam int IW = $clog2(ENTRIES);

    logic                  r_found;
    logic [IW-1:0]         r_pos;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic [IW-1:0]         n_pos;
    logic [VALUE_BITS-1:0] n_hit_val;

    // OR together position and value of the single matching cell
    always_comb begin
        n_pos     = '0;
        n_hit_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_match[i]) begin
                n_pos     = n_pos | IW'(i);
                n_hit_val = n_hit_val | i_val[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found   <= |i_match;
        r_pos     <= n_pos;
        r_hit_val <= n_hit_val;
    end

    assign o_found   = r_found;
    assign o_pos     = r_pos;
    assign o_hit_val = r_hit_val;

endmodule

@@ rtl/lkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer of the store: takes a request, steps through compare, encode
// and update, keeps occupancy, limit and counters, and holds the response.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lkv_req_if.sink                       i_req,
    lkv_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic                          i_found,
    input  logic [VALUE_BITS-1:0]         i_hit_val,
    output lkv_pkg::t_shift               o_op,
    output logic [$clog2(ENTRIES+1)-1:0]  o_used,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [VALUE_BITS-1:0]         o_load_val
);
    import lkv_pkg::*;

    localparam int CW = $clog2(ENTRIES+1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    t_state                r_state, n_state;
    t_action               r_action;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_vin;
    logic [CW-1:0]         r_used, n_used;
    logic [CAP_W-1:0]      r_cap;
    logic [COUNT_W-1:0]    r_hits, n_hits;
    logic [COUNT_W-1:0]    r_misses, n_misses;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [VALUE_BITS-1:0] r_out_val, n_out_val;
    logic [OCC_W-1:0]      r_out_occ, n_out_occ;
    logic [LW-1:0]         w_lim;
    logic [LW-1:0]         w_used_ext;
    logic [LW-1:0]         w_n_used_ext;
    logic                  w_go;
    logic                  w_accept;

    // Effective limit: zero counts as one, saturate at the row length
    always_comb begin
        if (r_cap == '0) begin
            w_lim = LW'(1);
        end else if (LW'(r_cap) > LW'(ENTRIES)) begin
            w_lim = LW'(ENTRIES);
        end else begin
            w_lim = LW'(r_cap);
        end
    end

    assign w_used_ext   = LW'(r_used);
    assign w_n_used_ext = LW'(n_used);
    assign w_accept     = i_req.valid && (r_state == ST_IDLE);
    assign w_go         = !r_out_valid || o_rsp.ready;

    // Next state, row command and response
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_val   = r_out_val;
        n_out_occ   = r_out_occ;
        o_op        = SH_HOLD;
        o_load_val  = r_vin;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_ENCODE;
            end
            ST_ENCODE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_go) begin
                    n_state     = ST_IDLE;
                    n_out_found = 1'b0;
                    n_out_val   = '0;
                    unique case (r_action)
                        ACT_GET: begin
                            if (i_found) begin
                                o_op        = SH_TOUCH;
                                o_load_val  = i_hit_val;
                                n_hits      = r_hits + COUNT_W'(1);
                                n_out_found = 1'b1;
                                n_out_val   = i_hit_val;
                            end else begin
                                n_misses = r_misses + COUNT_W'(1);
                            end
                        end
                        ACT_PUT: begin
                            n_out_found = i_found;
                            if (i_found) begin
                                o_op = SH_TOUCH;
                            end else begin
                                // Full: the oldest entry leaves the valid prefix
                                o_op = SH_INSERT;
                                if (w_used_ext < w_lim) begin
                                    n_used = r_used + CW'(1);
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            n_out_found = i_found;
                            if (i_found) begin
                                o_op   = SH_REMOVE;
                                n_used = r_used - CW'(1);
                            end
                        end
                        ACT_EXISTS: begin
                            n_out_found = i_found;
                        end
                        ACT_CLEAR: begin
                            n_used = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_out_occ   = w_n_used_ext[OCC_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_cap       <= CAP_RESET;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Request and response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= t_action'(i_req.action);
            r_key    <= i_req.key[KEY_BITS-1:0];
            r_vin    <= i_req.value_in[VALUE_BITS-1:0];
        end
        r_out_found <= n_out_found;
        r_out_val   <= n_out_val;
        r_out_occ   <= n_out_occ;
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.value_out  = VALUE_W'(r_out_val);
    assign o_rsp.occupancy  = r_out_occ;
    assign o_rsp.hit_total  = r_hits;
    assign o_rsp.miss_total = r_misses;
    assign o_used           = r_used;
    assign o_key            = r_key;

endmodule
